// ===== rtl/core/servo_sine_oscillator_assert.svh =====
// Assertion macros shared by the servo sine oscillator modules.
`ifndef SERVO_SINE_OSCILLATOR_ASSERT_SVH
`define SERVO_SINE_OSCILLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SSO_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sso assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SSO_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sso assertion failed");

`endif

// ===== rtl/core/sso_pkg.sv =====
// Package with the types, constants and sine table of the servo sine oscillator.
package sso_pkg;

   // Phase accumulator and sine table geometry.
   localparam int PHASE_BITS = 16;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

   // Shared divider width: holds one full turn and a 16-bit period.
   localparam int DIV_W = (PHASE_BITS + 1 > 16) ? PHASE_BITS + 1 : 16;
   localparam logic [DIV_W-1:0] ONE_TURN = DIV_W'(1) << PHASE_BITS;

   // Width of the scaled wave value amplitude * sine + offset * 2^15.
   localparam int WAVE_W = 27;

   // Pi / 2 in Q2.30.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Command codes.
   localparam logic [2:0] CMD_TICK        = 3'd0;
   localparam logic [2:0] CMD_START       = 3'd1;
   localparam logic [2:0] CMD_STOP        = 3'd2;
   localparam logic [2:0] CMD_RESET_PHASE = 3'd3;
   localparam logic [2:0] CMD_SET_POS     = 3'd4;
   localparam logic [2:0] CMD_ATTACH      = 3'd5;
   localparam logic [2:0] CMD_DETACH      = 3'd6;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_AMPLITUDE   = 3'd0;
   localparam logic [2:0] REG_OFFSET      = 3'd1;
   localparam logic [2:0] REG_START_PHASE = 3'd2;
   localparam logic [2:0] REG_PERIOD      = 3'd3;
   localparam logic [2:0] REG_SAMPLE      = 3'd4;
   localparam logic [2:0] REG_REVERSE     = 3'd5;
   localparam logic [2:0] REG_TRIM        = 3'd6;

   // Input and result transactions.
   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] position;
   } sso_req_type;

   typedef struct packed {
      logic signed [9:0] servo_angle;
      logic              from_wave;
   } sso_rsp_type;

   // Control and status between the sequencer and the shared divider.
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // Quarter-wave sine table in Q1.15.
   typedef logic [15:0] sine_table_type [SINE_TABLE_DEPTH+1];

   // Taylor series through x^15 in Q2.30, evaluated at elaboration.
   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    term;
      logic [63:0]    sum;
      logic [63:0]    prod;
      logic [63:0]    q;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
         x2 = (x * x) >> 30;
         term = x;
         sum = x;
         for (int k = 1; k <= 7; k++) begin
            prod = (term * x2) >> 30;
            case (k)
               1: term = prod / 6;
               2: term = prod / 20;
               3: term = prod / 42;
               4: term = prod / 72;
               5: term = prod / 110;
               6: term = prod / 156;
               7: term = prod / 210;
               default: term = 64'd0;
            endcase
            if ((k & 1) == 1) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         q = (sum + 64'd16384) >> 15;
         if (q > 64'd32767) begin
            q = 64'd32767;
         end
         tab[i] = q[15:0];
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

// ===== rtl/core/sso_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`include "servo_sine_oscillator_assert.svh"

module sso_div
   import sso_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quot_ff, quot_in;
   logic [DIV_W-1:0] divisor_ff, divisor_in;
   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   diff;
   logic             fits;

   // One trial subtraction of the shifted remainder.
   assign shifted = {rem_ff, quot_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = (shifted >= {1'b0, divisor_ff});

   // Step sequencing: load on start, then DIV_W steps.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(DIV_W);
         rem_in     = '0;
         quot_in    = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quot_in = {quot_ff[DIV_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   // A new division never starts on top of a running one.
   `SSO_ASSERT_IMPL(a_no_restart, clock, reset, div_req.start, !busy_ff)
   // The result pulse comes only once the steps are finished.
   `SSO_ASSERT_IMPL(a_done_idle, clock, reset, done_ff, !busy_ff)
   // The last step always raises the result pulse.
   `SSO_ASSERT_NEXT(a_last_step, clock, reset,
                    busy_ff && !div_req.start && cnt_ff == CNT_W'(1), done_ff)

endmodule

// ===== rtl/core/servo_sine_oscillator.sv =====
// Top level of the servo sine oscillator: sequencer, sine lookup and APB registers.
//
//   Channel   Ports                     Direction  Moves
//   req       req_valid/ready/data      in         one command transaction
//   rsp       rsp_valid/ready/data      out        one servo angle transaction
//   csr       csr_psel ... csr_pready   in/out     APB register access, no wait states
//
// Commands other than a due tick and set position finish in the idle state; set position
// passes through the emit state to load the output register. A tick that takes a wave
// sample makes two passes through the shared one-bit-per-cycle divider. Reset clears the
// phase, the elapsed counter and the run and attach flags, and sets the registers to their
// defaults. A result waits in the output register; the next command is taken meanwhile,
// and only a second result stalls until the first is taken.
`include "servo_sine_oscillator_assert.svh"

module servo_sine_oscillator
   import sso_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sso_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sso_rsp_type rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV1  = 3'd1;
   localparam logic [2:0] ST_DIV2  = 3'd2;
   localparam logic [2:0] ST_SINE  = 3'd3;
   localparam logic [2:0] ST_MULT  = 3'd4;
   localparam logic [2:0] ST_ANGLE = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   localparam int QUAD_W = PHASE_BITS - 1;
   localparam int IDX_PROD_W = PHASE_BITS - 1 + IDX_W;
   localparam logic [QUAD_W-1:0] QUARTER = QUAD_W'(1) << (PHASE_BITS - 2);

   // Configuration registers.
   logic [7:0]  amp_ff, amp_in;
   logic [7:0]  offset_ff, offset_in;
   logic [15:0] start_phase_ff, start_phase_in;
   logic [15:0] period_ff, period_in;
   logic [9:0]  sample_ff, sample_in;
   logic        reverse_ff, reverse_in;
   logic [7:0]  trim_ff, trim_in;

   // Sequencer and oscillator state.
   logic [2:0]              state_ff, state_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [15:0]             elapsed_ff, elapsed_in;
   logic                    running_ff, running_in;
   logic                    attached_ff, attached_in;
   logic [PHASE_BITS-1:0]   inc_ff, inc_in;
   logic signed [16:0]      sine_ff, sine_in;
   logic signed [WAVE_W-1:0] wave_ff, wave_in;
   logic signed [9:0]       pend_angle_ff, pend_angle_in;
   logic                    pend_wave_ff, pend_wave_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sso_rsp_type             rsp_data_ff, rsp_data_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                     csr_wr;
   logic [2:0]               csr_idx;
   logic                     out_free;
   logic [15:0]              elapsed_next;
   logic [23:0]              sp24;
   logic [23:0]              sp_shift;
   logic [PHASE_BITS-1:0]    p_sum;
   logic [1:0]               quad;
   logic [QUAD_W-1:0]        rr;
   logic [IDX_PROD_W-1:0]    idx_prod;
   logic [IDX_PROD_W-1:0]    idx_shift;
   logic [IDX_W-1:0]         idx;
   logic [15:0]              entry;
   logic signed [WAVE_W-1:0] prod;
   logic                     v_neg;
   logic [WAVE_W-1:0]        mag;
   logic [WAVE_W-1:0]        mag_rnd;
   logic signed [11:0]       rounded;
   logic signed [11:0]       signed_wave;
   logic signed [11:0]       trim_ext;

   // Clamp an angle to the ten-bit result range.
   function automatic logic signed [9:0] sat_angle(input logic signed [11:0] a);
      logic signed [9:0] r;
      if (a > 12'sd511) begin
         r = 10'sd511;
      end else if (a < -12'sd512) begin
         r = -10'sd512;
      end else begin
         r = a[9:0];
      end
      return r;
   endfunction

   sso_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Register port decode.
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      amp_in         = amp_ff;
      offset_in      = offset_ff;
      start_phase_in = start_phase_ff;
      period_in      = period_ff;
      sample_in      = sample_ff;
      reverse_in     = reverse_ff;
      trim_in        = trim_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_AMPLITUDE:   amp_in         = csr_pwdata[7:0];
            REG_OFFSET:      offset_in      = csr_pwdata[7:0];
            REG_START_PHASE: start_phase_in = csr_pwdata[15:0];
            REG_PERIOD:      period_in      = csr_pwdata[15:0];
            REG_SAMPLE:      sample_in      = csr_pwdata[9:0];
            REG_REVERSE:     reverse_in     = csr_pwdata[0];
            REG_TRIM:        trim_in        = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_AMPLITUDE:   csr_prdata = 32'(amp_ff);
         REG_OFFSET:      csr_prdata = 32'(offset_ff);
         REG_START_PHASE: csr_prdata = 32'(start_phase_ff);
         REG_PERIOD:      csr_prdata = 32'(period_ff);
         REG_SAMPLE:      csr_prdata = 32'(sample_ff);
         REG_REVERSE:     csr_prdata = 32'(reverse_ff);
         REG_TRIM:        csr_prdata = 32'(trim_ff);
         default:         csr_prdata = 32'd0;
      endcase
   end

   // Handshake.
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Saturating millisecond count for a tick.
   assign elapsed_next = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign trim_ext     = 12'(signed'(trim_ff));

   // Quarter-wave table lookup for the current phase plus start phase.
   assign sp24      = {start_phase_ff, 8'h00};
   assign sp_shift  = sp24 >> (24 - PHASE_BITS);
   assign p_sum     = phase_ff + sp_shift[PHASE_BITS-1:0];
   assign quad      = p_sum[PHASE_BITS-1 -: 2];
   assign rr        = quad[0] ? QUARTER - {1'b0, p_sum[PHASE_BITS-3:0]}
                              : {1'b0, p_sum[PHASE_BITS-3:0]};
   assign idx_prod  = IDX_PROD_W'(rr) * IDX_PROD_W'(SINE_TABLE_DEPTH);
   assign idx_shift = idx_prod >> (PHASE_BITS - 2);
   assign idx       = (idx_shift > IDX_PROD_W'(SINE_TABLE_DEPTH))
                      ? IDX_W'(SINE_TABLE_DEPTH) : idx_shift[IDX_W-1:0];
   assign entry     = SINE_TABLE[idx];

   // Amplitude scaling.
   assign prod = WAVE_W'(signed'({1'b0, amp_ff})) * WAVE_W'(sine_ff);

   // Round half away from zero, then apply direction.
   assign v_neg       = wave_ff[WAVE_W-1];
   assign mag         = v_neg ? WAVE_W'(-wave_ff) : WAVE_W'(wave_ff);
   assign mag_rnd     = mag + WAVE_W'(16384);
   assign rounded     = v_neg ? -signed'({1'b0, mag_rnd[25:15]})
                              : signed'({1'b0, mag_rnd[25:15]});
   assign signed_wave = reverse_ff ? -rounded : rounded;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      elapsed_in    = elapsed_ff;
      running_in    = running_ff;
      attached_in   = attached_ff;
      inc_in        = inc_ff;
      sine_in       = sine_ff;
      wave_in       = wave_ff;
      pend_angle_in = pend_angle_ff;
      pend_wave_in  = pend_wave_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      div_req       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.cmd)
                  CMD_TICK: begin
                     if (attached_ff && elapsed_next > {6'd0, sample_ff}) begin
                        elapsed_in       = 16'd0;
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(period_ff);
                        div_req.divisor  = (sample_ff == 10'd0) ? DIV_W'(1)
                                                                : DIV_W'(sample_ff);
                        state_in         = ST_DIV1;
                     end else begin
                        elapsed_in = elapsed_next;
                     end
                  end
                  CMD_START:       running_in = 1'b1;
                  CMD_STOP:        running_in = 1'b0;
                  CMD_RESET_PHASE: phase_in = '0;
                  CMD_SET_POS: begin
                     pend_angle_in = sat_angle(12'(req_data.position) + trim_ext);
                     pend_wave_in  = 1'b0;
                     state_in      = ST_EMIT;
                  end
                  CMD_ATTACH:      attached_in = 1'b1;
                  CMD_DETACH:      attached_in = 1'b0;
                  default: ;
               endcase
            end
         end
         ST_DIV1: begin
            // Samples per period done; now one turn over that count.
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = ONE_TURN;
               div_req.divisor  = (div_rsp.quotient == '0) ? DIV_W'(1) : div_rsp.quotient;
               state_in         = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               inc_in   = div_rsp.quotient[PHASE_BITS-1:0];
               state_in = ST_SINE;
            end
         end
         ST_SINE: begin
            sine_in  = quad[1] ? -signed'({1'b0, entry}) : signed'({1'b0, entry});
            state_in = ST_MULT;
         end
         ST_MULT: begin
            wave_in  = prod + signed'({4'd0, offset_ff, 15'd0});
            state_in = ST_ANGLE;
         end
         ST_ANGLE: begin
            phase_in = phase_ff + inc_ff;
            if (running_ff) begin
               pend_angle_in = sat_angle(signed_wave + trim_ext);
               pend_wave_in  = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            // Load the output register once it is free.
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.servo_angle = pend_angle_ff;
               rsp_data_in.from_wave   = pend_wave_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff         <= 8'd40;
         offset_ff      <= 8'd0;
         start_phase_ff <= 16'd0;
         period_ff      <= 16'd2500;
         sample_ff      <= 10'd30;
         reverse_ff     <= 1'b0;
         trim_ff        <= 8'd0;
         state_ff       <= ST_IDLE;
         phase_ff       <= '0;
         elapsed_ff     <= 16'd0;
         running_ff     <= 1'b0;
         attached_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         amp_ff         <= amp_in;
         offset_ff      <= offset_in;
         start_phase_ff <= start_phase_in;
         period_ff      <= period_in;
         sample_ff      <= sample_in;
         reverse_ff     <= reverse_in;
         trim_ff        <= trim_in;
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         elapsed_ff     <= elapsed_in;
         running_ff     <= running_in;
         attached_ff    <= attached_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      inc_ff        <= inc_in;
      sine_ff       <= sine_in;
      wave_ff       <= wave_in;
      pend_angle_ff <= pend_angle_in;
      pend_wave_ff  <= pend_wave_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // A pending result reaches the output register as soon as it is free.
   `SSO_ASSERT_NEXT(a_emit_loads, clock, reset, state_ff == ST_EMIT && !rsp_valid_ff,
                    rsp_valid_ff)
   // Divider results arrive only while the sequencer waits for them.
   `SSO_ASSERT_IMPL(a_div_in_wait, clock, reset, div_rsp.done,
                    state_ff == ST_DIV1 || state_ff == ST_DIV2)
   // Taking a sample clears the elapsed counter.
   `SSO_ASSERT_NEXT(a_sample_clears, clock, reset,
                    state_ff == ST_IDLE && state_in == ST_DIV1, elapsed_ff == 16'd0)

endmodule
